// ===== design/lz77_unary_code_depacker_defines.svh =====
// Assertion macros for the LZ77 depacker.
// Used by the top level only; no other dependencies.
`ifndef LZ77_UNARY_CODE_DEPACKER_DEFINES_SVH
`define LZ77_UNARY_CODE_DEPACKER_DEFINES_SVH
`ifndef SYNTH
`define LZD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define LZD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define LZD_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define LZD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/lzd_pkg.sv =====
// Shared types and constants for the LZ77 depacker.
// No dependencies.
`timescale 1ns / 1ps
package lzd_pkg;
  localparam int unsigned WinBits = 17;
  localparam int unsigned WinBytes = 1 << WinBits;
  localparam int unsigned BufBits = 32;
  localparam int unsigned HeldW = 6;

  typedef enum logic [2:0] {
    ST_ACCEPTED = 3'd0, ST_REFUSED = 3'd1, ST_BYTE = 3'd2,
    ST_NEED = 3'd3, ST_FINISHED = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    PH_HEADER, PH_TOKEN, PH_LEN_PREFIX, PH_LEN_BITS,
    PH_DIST_PREFIX, PH_DIST_BITS, PH_COPY, PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    BK_IDLE, BK_WORK, BK_READ, BK_OUT
  } bk_state_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] in_byte;
  } req_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] out_byte;
    logic       last;
  } res_t;
endpackage

// ===== design/lzd_if.sv =====
// Valid/ready channel interfaces for requests and results.
// Depends on lzd_pkg.
`timescale 1ns / 1ps
interface lzd_req_if;
  logic             valid;
  logic             ready;
  lzd_pkg::req_t    data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lzd_res_if;
  logic             valid;
  logic             ready;
  lzd_pkg::res_t    data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/lz77_unary_code_depacker.sv =====
// LZ77 unary-code depacker: a request front with a queue and the decode back.
// A request is registered in the queue before the back takes it. A push is taken
// in the back and then delivered. A pull is taken, runs the parse steps of the
// token, then for a copied byte a history read and then a write, and is then
// delivered.
// Each request gives exactly one result; the back works on one request at a time.
// Depends on lzd_pkg, lzd_if, lzd_queue, lzd_back and the defines header.
`timescale 1ns / 1ps
`include "lz77_unary_code_depacker_defines.svh"
module lz77_unary_code_depacker (
  input logic clk,
  input logic rst_n,
  lzd_req_if.sink in_ch,
  lzd_res_if.source out_ch
);
  import lzd_pkg::*;
  logic full, not_empty, pop;
  req_t head;

  assign in_ch.ready = ~full;

  lzd_queue u_queue (
    .clk, .rst_n, .push(in_ch.valid & ~full), .push_data(in_ch.data),
    .full, .pop, .not_empty, .head
  );

  lzd_back u_back (
    .clk, .rst_n, .req_valid(not_empty), .req(head), .req_pop(pop),
    .res_valid(out_ch.valid), .res_ready(out_ch.ready), .res(out_ch.data)
  );

  `LZD_ASSERT_IMPL(a_pop_nonempty, clk, rst_n, pop, not_empty)
  `LZD_ASSERT_IMPL(a_last_is_byte, clk, rst_n, out_ch.valid && out_ch.data.last,
                   out_ch.data.status == ST_BYTE)
  `LZD_ASSERT_NEXT(a_out_after_pop, clk, rst_n, pop && !head.req_type, out_ch.valid)
endmodule

// ===== design/lzd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module lzd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== design/lzd_queue.sv =====
// Two-entry request queue between the front and the back.
// Depends on lzd_pkg.
`timescale 1ns / 1ps
module lzd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  lzd_pkg::req_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output lzd_pkg::req_t head
);
  import lzd_pkg::*;
  req_t q_r [2];
  logic [1:0] cnt_r;
  logic rd_r, wr_r;

  assign full = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign head = q_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r <= 1'b0;
      wr_r <= 1'b0;
    end else begin
      if (push) wr_r <= ~wr_r;
      if (pop) rd_r <= ~rd_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
    if (push) q_r[wr_r] <= push_data;
  end
endmodule

// ===== design/lzd_back.sv =====
// Decode engine: bit buffer, token parser, match copier and history window.
// Depends on lzd_pkg and lzd_ram.
`timescale 1ns / 1ps
module lzd_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          req_valid,
  input  lzd_pkg::req_t req,
  output logic          req_pop,
  output logic          res_valid,
  input  logic          res_ready,
  output lzd_pkg::res_t res
);
  import lzd_pkg::*;

  bk_state_t st_r, st_nxt;
  phase_t ph_r, ph_nxt;
  logic [BufBits-1:0] buf_r, buf_nxt;
  logic [HeldW-1:0] held_r, held_nxt;
  logic [31:0] size_r, size_nxt, cnt_r, cnt_nxt;
  logic [15:0] left_r, left_nxt;
  logic [16:0] dist_r, dist_nxt;
  logic [3:0] pc_r, pc_nxt;
  logic [WinBits-1:0] wpos_r, wpos_nxt;
  logic reached_r, reached_nxt;
  res_t res_r, res_nxt;

  logic we;
  logic [7:0] wdata, rdata;
  logic [WinBits-1:0] raddr;

  lzd_ram #(.Width(8), .Depth(WinBytes)) u_hist (
    .clk, .we, .waddr(wpos_r), .wdata, .raddr, .rdata
  );

  assign raddr = wpos_r - WinBits'(dist_r);
  assign res_valid = (st_r == BK_OUT);
  assign res = res_r;

  // Bits aligned so that the oldest held bit sits at the top.
  logic [BufBits-1:0] top;
  logic [4:0] nbits;
  logic [15:0] field;
  logic [31:0] emit_cnt;

  always_comb begin
    top = buf_r << (6'(BufBits) - held_r);
    field = 16'(top >> (6'(BufBits) - {1'b0, nbits}));
  end

  always_comb begin
    st_nxt = st_r; ph_nxt = ph_r; buf_nxt = buf_r; held_nxt = held_r;
    size_nxt = size_r; cnt_nxt = cnt_r; left_nxt = left_r; dist_nxt = dist_r;
    pc_nxt = pc_r; wpos_nxt = wpos_r; reached_nxt = reached_r; res_nxt = res_r;
    req_pop = 1'b0; we = 1'b0; wdata = 8'd0; nbits = 5'd1;
    emit_cnt = cnt_r + 32'd1;
    case (st_r)
      BK_IDLE: begin
        if (req_valid) begin
          req_pop = 1'b1;
          res_nxt = '{ST_ACCEPTED, 8'd0, 1'b0};
          if (!req.req_type) begin
            if (held_r <= 6'(BufBits - 8)) begin
              buf_nxt = {buf_r[BufBits-9:0], req.in_byte};
              held_nxt = held_r + 6'd8;
            end else res_nxt.status = ST_REFUSED;
            st_nxt = BK_OUT;
          end else st_nxt = BK_WORK;
        end
      end
      BK_WORK: begin
        case (ph_r)
          PH_HEADER: begin
            nbits = 5'd16;
            if (held_r < 6'd16) begin
              res_nxt.status = ST_NEED; st_nxt = BK_OUT;
            end else begin
              held_nxt = held_r - 6'd16;
              if (pc_r == 4'd0) begin
                size_nxt = {field, 16'd0}; pc_nxt = 4'd1;
              end else begin
                size_nxt = {size_r[31:16], field}; pc_nxt = 4'd0;
                ph_nxt = ({size_r[31:16], field} == 32'd0) ? PH_DONE : PH_TOKEN;
              end
            end
          end
          PH_TOKEN: begin
            nbits = 5'd9;
            if (held_r < 6'd1) begin
              res_nxt.status = ST_NEED; st_nxt = BK_OUT;
            end else if (!top[BufBits-1]) begin
              if (held_r < 6'd9) begin
                res_nxt.status = ST_NEED; st_nxt = BK_OUT;
              end else begin
                held_nxt = held_r - 6'd9;
                we = 1'b1; wdata = field[7:0];
                wpos_nxt = wpos_r + 1'b1; cnt_nxt = emit_cnt;
                reached_nxt = reached_r | (emit_cnt == size_r);
                res_nxt = '{ST_BYTE, field[7:0], 1'b0};
                if (reached_nxt) begin
                  ph_nxt = PH_DONE; res_nxt.last = 1'b1;
                end
                st_nxt = BK_OUT;
              end
            end else begin
              held_nxt = held_r - 6'd1; pc_nxt = 4'd1; ph_nxt = PH_LEN_PREFIX;
            end
          end
          PH_LEN_PREFIX, PH_DIST_PREFIX: begin
            if ((ph_r == PH_LEN_PREFIX && pc_r == 4'd15) ||
                (ph_r == PH_DIST_PREFIX && pc_r == 4'd7)) begin
              ph_nxt = (ph_r == PH_LEN_PREFIX) ? PH_LEN_BITS : PH_DIST_BITS;
            end else if (held_r < 6'd1) begin
              res_nxt.status = ST_NEED; st_nxt = BK_OUT;
            end else begin
              if (!top[BufBits-1])
                ph_nxt = (ph_r == PH_LEN_PREFIX) ? PH_LEN_BITS : PH_DIST_BITS;
              else pc_nxt = pc_r + 4'd1;
              held_nxt = held_r - 6'd1;
            end
          end
          PH_LEN_BITS: begin
            nbits = {1'b0, pc_r};
            if (held_r < {2'b0, pc_r}) begin
              res_nxt.status = ST_NEED; st_nxt = BK_OUT;
            end else begin
              left_nxt = (16'd1 << pc_r) + field;
              held_nxt = held_r - {2'b0, pc_r};
              pc_nxt = 4'd0; ph_nxt = PH_DIST_PREFIX;
            end
          end
          PH_DIST_BITS: begin
            nbits = {1'b0, pc_r} + 5'd9;
            if (held_r < {1'b0, nbits}) begin
              res_nxt.status = ST_NEED; st_nxt = BK_OUT;
            end else begin
              dist_nxt = ((17'd1 << pc_r) - 17'd1) * 17'd512 + {1'b0, field} + 17'd1;
              held_nxt = held_r - {1'b0, nbits};
              pc_nxt = 4'd0; ph_nxt = PH_COPY;
            end
          end
          PH_COPY: st_nxt = BK_READ;
          default: begin
            res_nxt.status = ST_FINISHED; st_nxt = BK_OUT;
          end
        endcase
      end
      BK_READ: begin
        // History data is back from the RAM this cycle.
        we = 1'b1; wdata = rdata;
        wpos_nxt = wpos_r + 1'b1; cnt_nxt = emit_cnt;
        reached_nxt = reached_r | (emit_cnt == size_r);
        res_nxt = '{ST_BYTE, rdata, 1'b0};
        if (left_r != 16'd0) left_nxt = left_r - 16'd1;
        if (left_r <= 16'd1) begin
          if (reached_nxt) begin
            ph_nxt = PH_DONE; res_nxt.last = 1'b1;
          end else ph_nxt = PH_TOKEN;
        end
        st_nxt = BK_OUT;
      end
      default: if (res_ready) st_nxt = BK_IDLE;
    endcase
    // Keep unheld bits at zero, as dropping bits clears them.
    if (held_nxt == 6'd0) buf_nxt = '0;
    else buf_nxt = buf_nxt & ({BufBits{1'b1}} >> (6'(BufBits) - held_nxt));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_IDLE; ph_r <= PH_HEADER; buf_r <= '0; held_r <= '0;
      size_r <= '0; cnt_r <= '0; left_r <= '0; dist_r <= '0; pc_r <= '0;
      wpos_r <= '0; reached_r <= 1'b0;
    end else begin
      st_r <= st_nxt; ph_r <= ph_nxt; buf_r <= buf_nxt; held_r <= held_nxt;
      size_r <= size_nxt; cnt_r <= cnt_nxt; left_r <= left_nxt; dist_r <= dist_nxt;
      pc_r <= pc_nxt; wpos_r <= wpos_nxt; reached_r <= reached_nxt;
    end
    res_r <= res_nxt;
  end
endmodule
